### sv/spr_pkg.sv
// ----------------------------------------------------------------------------
// Stream pattern replacer package
// Shared types and constants for the find-and-replace datapath.
// ----------------------------------------------------------------------------
package spr_pkg;

  // Widest pattern or replacement that a command can carry, in bytes.
  localparam int BYTES_MAX = 8;
  // Width of the packed byte registers.
  localparam int DATA_W    = 8 * BYTES_MAX;
  // Width of a length or byte count (holds 0 to BYTES_MAX).
  localparam int LEN_W     = 4;
  // Width of a byte position inside a command.
  localparam int IDX_W     = 3;

  // Configuration register map, in register order.
  typedef enum logic [1:0] {
    REG_PATTERN_BYTES,
    REG_PATTERN_LENGTH,
    REG_REPLACEMENT_BYTES,
    REG_REPLACEMENT_LENGTH
  } reg_idx_t;

  // Emit command: up to BYTES_MAX bytes, first byte lowest; a zero count
  // with the last flag set asks for an empty end marker.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  count;
    logic              last;
  } cmd_t;

endpackage

### sv/spr_front.sv
// ----------------------------------------------------------------------------
// Stream pattern replacer front end
// Accepts source bytes, keeps the match window and turns each byte into an
// emit command for the back end, pushed when the byte yields output or ends a string.
// ----------------------------------------------------------------------------
module spr_front #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  input  logic                       in_last,
  input  logic                       queue_full,
  input  logic                       window_clear,
  input  logic [spr_pkg::DATA_W-1:0] pattern_bytes,
  input  logic [spr_pkg::LEN_W-1:0]  pattern_length,
  input  logic [spr_pkg::DATA_W-1:0] replacement_bytes,
  input  logic [spr_pkg::LEN_W-1:0]  replacement_length,
  output logic                       push,
  output spr_pkg::cmd_t              cmd
);

  localparam int FW = $clog2(MAX_PATTERN + 1);

  logic [7:0]                window [MAX_PATTERN];
  logic [7:0]                win_new [MAX_PATTERN];
  logic [FW-1:0]             fill;
  logic [FW-1:0]             fill_base;
  logic [FW-1:0]             fill_inc;
  logic [spr_pkg::LEN_W-1:0] plen;
  logic [spr_pkg::LEN_W-1:0] rlen;
  logic [spr_pkg::DATA_W-1:0] win_vec;
  logic                      full;
  logic                      hit;
  logic                      accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Effective lengths: a zero pattern counts as one byte, both saturate.
  always_comb begin
    if (pattern_length == '0) begin
      plen = spr_pkg::LEN_W'(1);
    end else if (pattern_length > spr_pkg::LEN_W'(MAX_PATTERN)) begin
      plen = spr_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      plen = pattern_length;
    end
    if (replacement_length > spr_pkg::LEN_W'(MAX_REPLACEMENT)) begin
      rlen = spr_pkg::LEN_W'(MAX_REPLACEMENT);
    end else begin
      rlen = replacement_length;
    end
  end

  // Window with the new byte appended, and the pattern compare.
  always_comb begin
    fill_base = (spr_pkg::LEN_W'(fill) >= plen) ? '0 : fill;
    fill_inc  = fill_base + FW'(1);
    full      = (spr_pkg::LEN_W'(fill_inc) == plen);
    win_vec   = '0;
    hit       = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_new[k] = (fill_base == FW'(k)) ? in_byte : window[k];
      win_vec[8*k +: 8] = win_new[k];
      if ((spr_pkg::LEN_W'(k) < plen) && (win_new[k] != pattern_bytes[8*k +: 8])) begin
        hit = 1'b0;
      end
    end
  end

  // Classify the item into an emit command.
  always_comb begin
    cmd.last = in_last;
    if (full && hit) begin
      cmd.data  = replacement_bytes;
      cmd.count = rlen;
    end else if (full) begin
      // Oldest byte goes out; on the last item the rest follows it.
      cmd.data  = win_vec;
      cmd.count = in_last ? plen : spr_pkg::LEN_W'(1);
    end else begin
      cmd.data  = win_vec;
      cmd.count = in_last ? spr_pkg::LEN_W'(fill_inc) : '0;
    end
  end

  assign push = accept && ((cmd.count != '0) || in_last);

  // Window fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (window_clear) begin
      fill <= '0;
    end else if (accept) begin
      if (in_last || (full && hit)) begin
        fill <= '0;
      end else if (full) begin
        fill <= FW'(plen - spr_pkg::LEN_W'(1));
      end else begin
        fill <= fill_inc;
      end
    end
  end

  // Window contents: shift down when the window is full, else keep the appended byte.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (full && (k < MAX_PATTERN - 1)) begin
          window[k] <= win_new[(k + 1) % MAX_PATTERN];
        end else begin
          window[k] <= win_new[k];
        end
      end
    end
  end

endmodule

### sv/spr_queue.sv
// ----------------------------------------------------------------------------
// Stream pattern replacer command queue
// Two-entry queue of emit commands between the front and back ends.
// ----------------------------------------------------------------------------
module spr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output spr_pkg::cmd_t head,
  output logic          not_empty,
  output logic          full
);

  spr_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    used;

  assign head      = entries[rd_ptr];
  assign not_empty = (used != 2'd0);
  assign full      = (used == 2'd2);

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        used <= used + 2'd1;
      end else if (pop && !push) begin
        used <= used - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

### sv/spr_back.sv
// ----------------------------------------------------------------------------
// Stream pattern replacer back end
// Plays out the head command one result item per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module spr_back (
  input  logic          clk,
  input  logic          rst,
  input  spr_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          out_empty
);

  logic [spr_pkg::IDX_W-1:0] idx;
  logic                      marker;
  logic                      final_byte;
  logic                      take;

  assign marker     = (head.count == '0);
  assign final_byte = (spr_pkg::LEN_W'(idx) + spr_pkg::LEN_W'(1)) == head.count;
  assign out_valid  = head_valid;
  assign take       = out_valid && out_ready;
  assign pop        = take && (marker || final_byte);

  // Result fields straight from the registered queue head.
  always_comb begin
    if (marker) begin
      out_byte  = 8'd0;
      out_last  = 1'b1;
      out_empty = 1'b1;
    end else begin
      out_byte  = head.data[8*idx +: 8];
      out_last  = head.last && final_byte;
      out_empty = 1'b0;
    end
  end

  // Byte position within the head command.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop) begin
      idx <= '0;
    end else if (take) begin
      idx <= idx + spr_pkg::IDX_W'(1);
    end
  end

endmodule

### sv/stream_pattern_replacer_top.sv
// Results of an accepted item pass through the registered command queue.
// Throughput: one item per cycle while each item yields at most one result
// and the receiver is ready; an item with several results holds the output
// until all are taken, and the two-entry queue buffers two emit commands.
// Reset (synchronous, rst high) empties the window and the queue and loads
// the register defaults: pattern length 1, all else zero.
// ----------------------------------------------------------------------------
// Stream pattern replacer top level
// Byte stream find-and-replace with an APB-style register port.
// ----------------------------------------------------------------------------
module stream_pattern_replacer_top #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Source stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] out_empty
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [spr_pkg::DATA_W-1:0] pattern_bytes;
  logic [spr_pkg::LEN_W-1:0]  pattern_length;
  logic [spr_pkg::DATA_W-1:0] replacement_bytes;
  logic [spr_pkg::LEN_W-1:0]  replacement_length;
  spr_pkg::reg_idx_t          reg_sel;
  logic                       cfg_write;
  logic                       window_clear;
  logic                       push;
  logic                       pop;
  logic                       queue_full;
  logic                       head_valid;
  spr_pkg::cmd_t              push_cmd;
  spr_pkg::cmd_t              head;

  assign pready       = 1'b1;
  assign reg_sel      = spr_pkg::reg_idx_t'(paddr[4:3]);
  assign cfg_write    = psel && penable && pwrite && pready;
  assign window_clear = cfg_write && (reg_sel == spr_pkg::REG_PATTERN_LENGTH);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= spr_pkg::LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        spr_pkg::REG_PATTERN_BYTES:      pattern_bytes      <= pwdata;
        spr_pkg::REG_PATTERN_LENGTH:     pattern_length     <= pwdata[spr_pkg::LEN_W-1:0];
        spr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes  <= pwdata;
        spr_pkg::REG_REPLACEMENT_LENGTH: replacement_length <= pwdata[spr_pkg::LEN_W-1:0];
        default:                         pattern_bytes      <= pattern_bytes;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_sel)
      spr_pkg::REG_PATTERN_BYTES:      prdata = pattern_bytes;
      spr_pkg::REG_PATTERN_LENGTH:     prdata = 64'(pattern_length);
      spr_pkg::REG_REPLACEMENT_BYTES:  prdata = replacement_bytes;
      spr_pkg::REG_REPLACEMENT_LENGTH: prdata = 64'(replacement_length);
      default:                         prdata = '0;
    endcase
  end

  spr_front #(
    .MAX_PATTERN    (MAX_PATTERN),
    .MAX_REPLACEMENT(MAX_REPLACEMENT)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_axis_tvalid),
    .in_ready          (s_axis_tready),
    .in_byte           (s_axis_tdata),
    .in_last           (s_axis_tlast),
    .queue_full        (queue_full),
    .window_clear      (window_clear),
    .pattern_bytes     (pattern_bytes),
    .pattern_length    (pattern_length),
    .replacement_bytes (replacement_bytes),
    .replacement_length(replacement_length),
    .push              (push),
    .cmd               (push_cmd)
  );

  spr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .not_empty(head_valid),
    .full     (queue_full)
  );

  spr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_empty (m_axis_tuser)
  );

endmodule

### sv/spr_checker.sv
// ----------------------------------------------------------------------------
// Stream pattern replacer checker
// Port-level properties of the replacer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module spr_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  // An empty marker always closes the string and carries a zero byte.
  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("empty marker without end of string or with data");

  // With nothing queued for output the input side must be open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty queue");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered straight after reset");

endmodule

bind stream_pattern_replacer_top spr_checker u_spr_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stream pattern replacer testbench
// Drives byte strings into the replacer, predicts the rewritten stream from
// its own copy of the window and registers, and checks every result item in
// order. Directed strings cover the register extremes and the corner cases;
// random strings built from pattern fragments then run under three idling
// profiles on the two stream sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT  = 400000;
  // Cycles allowed for items that yield no result before a register write.
  localparam int QUIET_CYCLES = 8;

  // One item of the rewritten stream.
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } out_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [7:0] out_byte
  logic        m_axis_tlast;
  logic        m_axis_tuser;           // [0] out_empty
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [63:0] pwdata = 64'd0;
  logic [63:0] prdata;
  logic        pready;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int errors        = 0;
  int cycle_count   = 0;

  // Predictor copy of the registers and the match window.
  logic [spr_pkg::DATA_W-1:0] pat_bytes = '0;
  logic [spr_pkg::LEN_W-1:0]  pat_len   = 4'd1;
  logic [spr_pkg::DATA_W-1:0] rep_bytes = '0;
  logic [spr_pkg::LEN_W-1:0]  rep_len   = 4'd0;
  logic [7:0]                 win [spr_pkg::BYTES_MAX];
  int                         win_fill  = 0;

  // Rewritten items still to arrive, oldest first.
  out_item_t rewritten_q[$];

  stream_pattern_replacer_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk = ~clk;

  // Run guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Pattern length as the block uses it: zero counts as one, large values saturate.
  function automatic int eff_pattern_len();
    if (pat_len == 0) return 1;
    if (pat_len > spr_pkg::BYTES_MAX) return spr_pkg::BYTES_MAX;
    return int'(pat_len);
  endfunction

  // Works out the items that one accepted source byte produces.
  task automatic predict_rewrite(input logic [7:0] b, input logic last);
    out_item_t outs[$];
    int        plen;
    int        rlen;
    bit        hit;
    plen = eff_pattern_len();
    rlen = (rep_len > spr_pkg::BYTES_MAX) ? spr_pkg::BYTES_MAX : int'(rep_len);
    if (win_fill >= plen) win_fill = 0;
    win[win_fill] = b;
    win_fill++;
    if (win_fill == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++) begin
        if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (int i = 0; i < rlen; i++) begin
          outs.insert(outs.size(), out_item_t'{rep_bytes[8*i +: 8], 1'b0, 1'b0});
        end
        win_fill = 0;
      end else begin
        outs.insert(outs.size(), out_item_t'{win[0], 1'b0, 1'b0});
        for (int i = 1; i < win_fill; i++) win[i-1] = win[i];
        win_fill--;
      end
    end
    // End of string: flush the window, or send a bare end marker.
    if (last) begin
      for (int i = 0; i < win_fill; i++) begin
        outs.insert(outs.size(), out_item_t'{win[i], 1'b0, 1'b0});
      end
      win_fill = 0;
      if (outs.size() == 0) outs.insert(0, out_item_t'{8'h00, 1'b0, 1'b1});
      outs[outs.size()-1].last = 1'b1;
    end
    foreach (outs[k]) rewritten_q.insert(rewritten_q.size(), outs[k]);
  endtask

  // Sends one source byte, with a random gap before it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    predict_rewrite(b, last);
  endtask

  // Holds the source back until every predicted item has arrived.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (rewritten_q.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Register write over the APB port: setup cycle, then access cycle.
  task automatic write_reg(input spr_pkg::reg_idx_t idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      spr_pkg::REG_PATTERN_BYTES:      pat_bytes = value;
      spr_pkg::REG_PATTERN_LENGTH: begin
        pat_len  = value[spr_pkg::LEN_W-1:0];
        win_fill = 0;
      end
      spr_pkg::REG_REPLACEMENT_BYTES:  rep_bytes = value;
      spr_pkg::REG_REPLACEMENT_LENGTH: rep_len = value[spr_pkg::LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Result checker and receiver back-pressure.
  always @(posedge clk) begin
    out_item_t want;
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (rewritten_q.size() == 0) begin
        $error("result item with nothing pending: out_byte %h", m_axis_tdata);
        errors++;
      end else begin
        want = rewritten_q.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("out_byte mismatch: expected %h, actual %h", want.data, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("out_last mismatch: expected %b, actual %b", want.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser !== want.empty) begin
          $error("out_empty mismatch: expected %b, actual %b", want.empty, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Reset defaults delete zero bytes; a deleted final byte gives a bare end marker.
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // Longest pattern and longest replacement: one item yields eight results.
  task automatic test_max_lengths();
    wait_quiet();
    write_reg(spr_pkg::REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(spr_pkg::REG_PATTERN_LENGTH, 64'd8);
    write_reg(spr_pkg::REG_REPLACEMENT_BYTES, 64'h00FF_A55A_0F1E_2D80);
    write_reg(spr_pkg::REG_REPLACEMENT_LENGTH, 64'd8);
    for (int i = 0; i < 8; i++) send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Zero pattern length acts as one; lengths above eight saturate.
  task automatic test_length_saturation();
    wait_quiet();
    write_reg(spr_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0000_005A);
    write_reg(spr_pkg::REG_PATTERN_LENGTH, 64'd0);
    write_reg(spr_pkg::REG_REPLACEMENT_LENGTH, 64'd15);
    send_byte(8'h5A, 1'b1);
    wait_quiet();
    write_reg(spr_pkg::REG_PATTERN_LENGTH, 64'd9);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
  endtask

  // A pattern length write part way through a string drops the window.
  task automatic test_midstring_length_write();
    wait_quiet();
    write_reg(spr_pkg::REG_PATTERN_BYTES, 64'h0000_0000_4443_4241);
    write_reg(spr_pkg::REG_PATTERN_LENGTH, 64'd4);
    write_reg(spr_pkg::REG_REPLACEMENT_LENGTH, 64'd2);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    wait_quiet();
    write_reg(spr_pkg::REG_PATTERN_LENGTH, 64'd4);
    send_byte(8'h43, 1'b0);
    send_byte(8'h44, 1'b1);
  endtask

  // Random strings made mostly of whole and partial pattern copies.
  task automatic test_random_strings(input int src_pct, input int sink_pct, input int n_items,
                                     input int first_plen, input int first_rlen);
    logic [7:0]  str[$];
    logic [63:0] pat;
    int          sent;
    int          strings;
    int          plen;
    int          target;
    int          r;
    int          n;
    bit          noise;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    wait_quiet();
    write_reg(spr_pkg::REG_PATTERN_BYTES, {$urandom, $urandom});
    write_reg(spr_pkg::REG_PATTERN_LENGTH, 64'(first_plen));
    write_reg(spr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
    write_reg(spr_pkg::REG_REPLACEMENT_LENGTH, 64'(first_rlen));
    sent    = 0;
    strings = 0;
    while (sent < n_items) begin
      // New register setting every few strings.
      if (strings % 4 == 3) begin
        wait_quiet();
        if ($urandom_range(1)) begin
          pat = {$urandom, $urandom};
        end else begin
          for (int k = 0; k < 8; k++) pat[8*k +: 8] = 8'(8'h41 + $urandom_range(1));
        end
        write_reg(spr_pkg::REG_PATTERN_BYTES, pat);
        r = $urandom_range(9);
        write_reg(spr_pkg::REG_PATTERN_LENGTH,
                  64'((r == 0) ? 0 : (r == 1) ? $urandom_range(15, 9) : $urandom_range(8, 1)));
        write_reg(spr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
        write_reg(spr_pkg::REG_REPLACEMENT_LENGTH,
                  64'(($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8, 0)));
      end
      // Build one string from fragments.
      plen   = eff_pattern_len();
      target = $urandom_range(16, 1);
      noise  = ($urandom_range(7) == 0);
      str.delete();
      while (str.size() < target) begin
        r = noise ? 9 : $urandom_range(9);
        if (r < 5) begin
          for (int k = 0; k < plen; k++) str.insert(str.size(), pat_bytes[8*k +: 8]);
        end else if (r < 7) begin
          n = $urandom_range(plen - 1, 0);
          for (int k = 0; k < n; k++) str.insert(str.size(), pat_bytes[8*k +: 8]);
        end else if (r < 9) begin
          str.insert(str.size(), pat_bytes[8*$urandom_range(plen - 1) +: 8]);
        end else begin
          str.insert(str.size(), 8'($urandom_range(255)));
        end
      end
      foreach (str[k]) begin
        if ($urandom_range(39) == 0) wait_quiet();
        send_byte(str[k], k == str.size() - 1);
        sent++;
      end
      strings++;
    end
  endtask

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle_pct  = 26;
    sink_idle_pct = 81;
    test_reset_defaults();
    test_max_lengths();
    test_length_saturation();
    test_midstring_length_write();
    test_random_strings(26, 81, 40, 1, 8);
    test_random_strings(81, 26, 40, 8, 0);
    test_random_strings(0, 0, 40, 4, 3);
    wait_quiet();
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
sv/spr_pkg.sv
sv/spr_front.sv
sv/spr_queue.sv
sv/spr_back.sv
sv/stream_pattern_replacer_top.sv
sv/spr_checker.sv
tb/tb.sv
